// File: design/dsu_pkg.sv
package dsu_pkg;

  localparam int ELEM_W   = 6;
  localparam int ELEM_CNT = 2 ** ELEM_W;
  localparam int RANK_W   = 3;
  localparam int CNT_W    = 32;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // variant register bits
  localparam int VAR_RANK_BIT = 0;
  localparam int VAR_COMP_BIT = 1;
  localparam logic [1:0] VARIANT_RESET = 2'd3;

  typedef enum logic [1:0] {
    OP_MAKE  = 2'd0,
    OP_UNION = 2'd1,
    OP_FIND  = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_NEXT,
    ST_LINK,
    ST_BUMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              status;
    logic [ELEM_W-1:0] root;
    logic [CNT_W-1:0]  find_calls;
  } result_t;

endpackage

// File: design/dsu_in_if.sv
interface dsu_in_if;
  import dsu_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [ELEM_W-1:0] elem_a;
  logic [ELEM_W-1:0] elem_b;

  modport source (output valid, output operation, output elem_a, output elem_b,
                  input ready);
  modport sink (input valid, input operation, input elem_a, input elem_b,
                output ready);
endinterface

// File: design/dsu_out_if.sv
interface dsu_out_if;
  import dsu_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [ELEM_W-1:0] root;
  logic [CNT_W-1:0]  find_calls;

  modport source (output valid, output status, output root, output find_calls,
                  input ready);
  modport sink (input valid, input status, input root, input find_calls,
                output ready);
endinterface

// File: design/dsu_ram.sv
module dsu_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/dsu_ctrl.sv
module dsu_ctrl #(
  parameter int NUM_ELEMENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dsu_in_if.sink                         in_ch,
  input  logic [1:0]                     variant,
  output logic                           mem_we,
  output logic [$clog2(NUM_ELEMENTS)-1:0] mem_addr,
  output logic [$clog2(NUM_ELEMENTS)+dsu_pkg::RANK_W-1:0] mem_wdata,
  input  logic [$clog2(NUM_ELEMENTS)+dsu_pkg::RANK_W-1:0] mem_rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output dsu_pkg::result_t               res
);
  import dsu_pkg::*;

  localparam int IDX_W = $clog2(NUM_ELEMENTS);
  localparam int W     = IDX_W + RANK_W;
  localparam int XW    = (IDX_W > ELEM_W) ? IDX_W : ELEM_W;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [IDX_W-1:0]    b_idx_r, b_idx_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    start_r, start_nxt;
  logic [IDX_W-1:0]    walk_r, walk_nxt;
  logic [IDX_W-1:0]    root_r, root_nxt;
  logic [IDX_W-1:0]    ra_r, ra_nxt;
  logic [RANK_W-1:0]   rka_r, rka_nxt;
  logic [RANK_W-1:0]   rkb_r, rkb_nxt;
  logic                phase_r, phase_nxt;
  logic                res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_root_r, res_root_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ELEM_CNT-1:0] created_r, created_nxt;
  logic                cnt_inc;

  logic                in_fire;
  op_t                 in_op;
  logic [XW-1:0]       a_ext, b_ext, root_ext;
  logic [IDX_W-1:0]    a_idx, b_idx;
  logic                a_in_range, b_in_range;
  logic                pa, pb, make_ok;
  logic [IDX_W-1:0]    rd_parent;
  logic [RANK_W-1:0]   rd_rank;
  logic                by_rank, compress, a_wins;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_op       = op_t'(in_ch.operation);

  assign a_ext = XW'(in_ch.elem_a);
  assign b_ext = XW'(in_ch.elem_b);
  assign a_idx = a_ext[IDX_W-1:0];
  assign b_idx = b_ext[IDX_W-1:0];

  assign a_in_range = 32'(in_ch.elem_a) < 32'(NUM_ELEMENTS);
  assign b_in_range = 32'(in_ch.elem_b) < 32'(NUM_ELEMENTS);
  assign pa         = a_in_range && created_r[in_ch.elem_a];
  assign pb         = b_in_range && created_r[in_ch.elem_b];
  assign make_ok    = a_in_range && !created_r[in_ch.elem_a];

  assign rd_parent = mem_rdata[W-1:RANK_W];
  assign rd_rank   = mem_rdata[RANK_W-1:0];

  assign by_rank  = variant[VAR_RANK_BIT];
  assign compress = variant[VAR_COMP_BIT];
  assign a_wins   = !by_rank || (rka_r >= rkb_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_UNION: state_nxt = (pa && pb) ? ST_FIND_CHK : ST_DONE;
            OP_FIND:  state_nxt = pa ? ST_FIND_CHK : ST_DONE;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FIND_CHK: begin
        if (rd_parent == cur_r) begin
          state_nxt = (compress && (start_r != cur_r)) ? ST_COMP_WR : ST_NEXT;
        end
      end
      ST_COMP_RD: state_nxt = ST_COMP_WR;
      ST_COMP_WR: state_nxt = (rd_parent == root_r) ? ST_NEXT : ST_COMP_RD;
      ST_NEXT: begin
        if (op_r == OP_FIND) begin
          state_nxt = ST_DONE;
        end else if (!phase_r) begin
          state_nxt = ST_FIND_CHK;
        end else begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        if ((ra_r != root_r) && a_wins && by_rank && (rka_r == rkb_r) &&
            (rka_r != RANK_MAX)) begin
          state_nxt = ST_BUMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BUMP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    op_nxt         = op_r;
    b_idx_nxt      = b_idx_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    walk_nxt       = walk_r;
    root_nxt       = root_r;
    ra_nxt         = ra_r;
    rka_nxt        = rka_r;
    rkb_nxt        = rkb_r;
    phase_nxt      = phase_r;
    res_status_nxt = res_status_r;
    res_root_nxt   = res_root_r;
    created_nxt    = created_r;
    cnt_inc        = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = cur_r;
    mem_wdata      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_op;
          b_idx_nxt      = b_idx;
          cur_nxt        = a_idx;
          start_nxt      = a_idx;
          phase_nxt      = 1'b0;
          res_status_nxt = 1'b0;
          res_root_nxt   = '0;
          case (in_op)
            OP_MAKE: begin
              if (make_ok) begin
                mem_we                     = 1'b1;
                mem_addr                   = a_idx;
                mem_wdata                  = {a_idx, {RANK_W{1'b0}}};
                created_nxt[in_ch.elem_a] = 1'b1;
                res_root_nxt               = a_idx;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            OP_UNION: begin
              if (pa && pb) begin
                mem_addr = a_idx;
                cnt_inc  = 1'b1;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            OP_FIND: begin
              if (pa) begin
                mem_addr = a_idx;
                cnt_inc  = 1'b1;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIND_CHK: begin
        if (rd_parent != cur_r) begin
          // climb one level
          cur_nxt  = rd_parent;
          mem_addr = rd_parent;
          cnt_inc  = 1'b1;
        end else begin
          root_nxt = cur_r;
          if (!phase_r) begin
            ra_nxt  = cur_r;
            rka_nxt = rd_rank;
          end else begin
            rkb_nxt = rd_rank;
          end
          // start the compression pass at the walk origin
          mem_addr = start_r;
          walk_nxt = start_r;
        end
      end
      ST_COMP_RD: mem_addr = walk_r;
      ST_COMP_WR: begin
        mem_we    = 1'b1;
        mem_addr  = walk_r;
        mem_wdata = {root_r, rd_rank};
        walk_nxt  = rd_parent;
      end
      ST_NEXT: begin
        if (op_r == OP_FIND) begin
          res_root_nxt = root_r;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          cur_nxt   = b_idx_r;
          start_nxt = b_idx_r;
          mem_addr  = b_idx_r;
          cnt_inc   = 1'b1;
        end
      end
      ST_LINK: begin
        if (ra_r == root_r) begin
          res_root_nxt = ra_r;
        end else if (a_wins) begin
          mem_we       = 1'b1;
          mem_addr     = root_r;
          mem_wdata    = {ra_r, rkb_r};
          res_root_nxt = ra_r;
        end else begin
          mem_we       = 1'b1;
          mem_addr     = ra_r;
          mem_wdata    = {root_r, rka_r};
          res_root_nxt = root_r;
        end
      end
      ST_BUMP: begin
        mem_we    = 1'b1;
        mem_addr  = ra_r;
        mem_wdata = {ra_r, rka_r + 1'b1};
      end
      default: ;
    endcase
  end

  assign cnt_nxt = (cnt_inc && (cnt_r != '1)) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      created_r <= '0;
      phase_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      created_r <= created_nxt;
      phase_r   <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    b_idx_r      <= b_idx_nxt;
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    walk_r       <= walk_nxt;
    root_r       <= root_nxt;
    ra_r         <= ra_nxt;
    rka_r        <= rka_nxt;
    rkb_r        <= rkb_nxt;
    res_status_r <= res_status_nxt;
    res_root_r   <= res_root_nxt;
  end

  assign root_ext       = XW'(res_root_r);
  assign res_valid      = (state_r == ST_DONE);
  assign res.status     = res_status_r;
  assign res.root       = root_ext[ELEM_W-1:0];
  assign res.find_calls = cnt_r;

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r >= $past(cnt_r))
    else $error("find-call counter went backwards");

  a_comp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP_WR) && $past(rst_n) |->
      ($past(state_r) == ST_FIND_CHK) || ($past(state_r) == ST_COMP_RD))
    else $error("compression write without a preceding read");

  a_err_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_status_r |-> res_root_r == '0)
    else $error("error result carries a nonzero root");

  a_link_after_both: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK) |-> phase_r && (op_r == OP_UNION))
    else $error("link step reached before both walks finished");

endmodule

// File: design/dsu_out_stage.sv
module dsu_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  dsu_pkg::result_t res,
  dsu_out_if.source        out_ch
);
  import dsu_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;

  assign res_ready     = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = res_ready ? res_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the beat until taken
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_data_r.status;
  assign out_ch.root       = out_data_r.root;
  assign out_ch.find_calls = out_data_r.find_calls;

endmodule

// File: design/disjoint_set_union_find.sv
// Make, read-count and error beats go from accept to ST_DONE, then into the output register.
// Find: ST_FIND_CHK climbs one level per visit; ST_COMP_WR/ST_COMP_RD relink the path nodes.
// Union: both finds back to back, then ST_LINK, and ST_BUMP on a by-rank tie below RANK_MAX.
// One beat in flight: the next is taken only once the result has left for the output register.
// Reset: synchronous rst_n clears control, created flags, find counter; variant returns to 3.
// The parent/rank memory is not cleared; only created entries are ever used.
module disjoint_set_union_find #(
  parameter int NUM_ELEMENTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  dsu_in_if.sink     in_ch,
  dsu_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import dsu_pkg::*;

  localparam int IDX_W = $clog2(NUM_ELEMENTS);
  localparam int W     = IDX_W + RANK_W;

  // Variant register: bit 0 selects union by rank, bit 1 path compression.
  logic [1:0] variant_r, variant_nxt;

  assign variant_nxt = cfg_we ? cfg_wdata : variant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VARIANT_RESET;
    end else begin
      variant_r <= variant_nxt;
    end
  end

  // Memory port: each word is {parent, rank}; one access per cycle, read
  // data is registered. The sequencer walks a parent chain one level per
  // cycle and rewrites compressed links with a read/write pair per node.
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [W-1:0]     mem_wdata;
  logic [W-1:0]     mem_rdata;

  // Result handoff between the sequencer and the output register.
  logic    res_valid;
  logic    res_ready;
  result_t res;

  dsu_ram #(
    .WIDTH (W),
    .DEPTH (NUM_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  dsu_ctrl #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .variant   (variant_r),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register lets the sequencer take the next beat while a result
  // still waits downstream.
  dsu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

// File: dv/disjoint_set_union_find_tb.sv
module disjoint_set_union_find_tb;
  import dsu_pkg::*;

  // link scheme codes held in the variant register
  localparam logic [1:0] SCHEME_NAIVE  = 2'd0;
  localparam logic [1:0] SCHEME_RANK   = 2'd1;
  localparam logic [1:0] SCHEME_SQUASH = 2'd2;
  localparam logic [1:0] SCHEME_BOTH   = 2'd3;

  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 166;
  localparam int REPORT_CAP   = 10;
  localparam int WATCHDOG     = 4000;  // outlasts the longest union and the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 250;   // result beats seen before the long hold-off
  localparam int TAIL_CYCLES  = 16;

  typedef enum bit {ROW_BEAT, ROW_SCHEME} row_kind_t;

  // one line of the directed plan: a beat (optionally with a hand-typed result) or a
  // scheme change
  typedef struct packed {
    row_kind_t         kind;
    op_t               op;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic [1:0]        scheme;
    bit                known;
    result_t           want;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  dsu_in_if  in_ch ();
  dsu_out_if out_ch ();

  disjoint_set_union_find #(.NUM_ELEMENTS(ELEM_CNT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the disjoint-set state
  logic [ELEM_W-1:0] parent_of [ELEM_CNT];
  logic [RANK_W-1:0] rank_of [ELEM_CNT];
  bit                made [ELEM_CNT];
  logic [ELEM_W-1:0] made_list [$];
  logic [CNT_W-1:0]  find_levels;
  logic [1:0]        scheme;

  result_t     pending_results [$];
  plan_row_t   plan [$];
  int          errors;
  int          beats_rx;
  int          stall_cycles;
  int          op_seen [4];
  int          deepest_find;
  bit [3:0]    schemes_used;
  int unsigned tx_quiet;
  int unsigned rx_quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Draw the idle gap before the next beat; now and then start a run of back-to-back
  // beats so that stretches with no idling show up too.
  function automatic int unsigned draw_gap(inout int unsigned quiet);
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  // Climb from e to its root, counting every level including the root. With squash set,
  // relink every node on the path straight to the root.
  function automatic logic [ELEM_W-1:0] climb(input logic [ELEM_W-1:0] e, input bit squash);
    logic [ELEM_W-1:0] top;
    logic [ELEM_W-1:0] walk;
    logic [ELEM_W-1:0] nxt;
    int                steps;
    top = e;
    if (find_levels != '1) find_levels++;
    steps = 0;
    while (parent_of[top] != top && steps < ELEM_CNT) begin
      top = parent_of[top];
      if (find_levels != '1) find_levels++;
      steps++;
    end
    if (steps + 1 > deepest_find) deepest_find = steps + 1;
    if (squash) begin
      walk = e;
      steps = 0;
      while (walk != top && steps < ELEM_CNT) begin
        nxt = parent_of[walk];
        parent_of[walk] = top;
        walk = nxt;
        steps++;
      end
    end
    return top;
  endfunction

  // Apply one accepted beat to the shadow state and return the result it must produce.
  function automatic result_t dsu_apply(input op_t op, input logic [ELEM_W-1:0] a,
                                        input logic [ELEM_W-1:0] b);
    result_t           r;
    logic [ELEM_W-1:0] ra;
    logic [ELEM_W-1:0] rb;
    bit                by_rank;
    bit                squash;
    by_rank = scheme[VAR_RANK_BIT];
    squash  = scheme[VAR_COMP_BIT];
    r = '0;
    case (op)
      OP_MAKE: begin
        if (made[a]) begin
          r.status = 1'b1;
        end else begin
          made[a]      = 1'b1;
          parent_of[a] = a;
          rank_of[a]   = '0;
          made_list.push_back(a);
          r.root = a;
        end
      end
      OP_UNION: begin
        if (!made[a] || !made[b]) begin
          r.status = 1'b1;
        end else begin
          ra = climb(a, squash);
          rb = climb(b, squash);
          if (ra == rb) begin
            r.root = ra;
          end else if (!by_rank || rank_of[ra] >= rank_of[rb]) begin
            // first operand's root wins; under union by rank a tie lifts the winner's rank below RANK_MAX
            parent_of[rb] = ra;
            if (by_rank && rank_of[ra] == rank_of[rb] && rank_of[ra] != RANK_MAX)
              rank_of[ra]++;
            r.root = ra;
          end else begin
            parent_of[ra] = rb;
            r.root = rb;
          end
        end
      end
      OP_FIND: begin
        if (!made[a]) r.status = 1'b1;
        else r.root = climb(a, squash);
      end
      default: ;
    endcase
    r.find_calls = find_levels;
    return r;
  endfunction

  task automatic plan_item(input op_t op, input logic [ELEM_W-1:0] a,
                           input logic [ELEM_W-1:0] b, input bit known, input logic st,
                           input logic [ELEM_W-1:0] rt, input logic [CNT_W-1:0] cnt);
    plan_row_t row;
    row.kind   = ROW_BEAT;
    row.op     = op;
    row.a      = a;
    row.b      = b;
    row.scheme = scheme;
    row.known  = known;
    row.want   = '{status: st, root: rt, find_calls: cnt};
    plan.push_back(row);
  endtask

  task automatic plan_scheme(input logic [1:0] v);
    plan_row_t row;
    row = '0;
    row.kind   = ROW_SCHEME;
    row.scheme = v;
    plan.push_back(row);
  endtask

  // Offer one beat after a random gap, hold it until taken, then predict its result.
  // A hand-typed result, when given, replaces the predicted one in the queue.
  task automatic send_beat(input op_t op, input logic [ELEM_W-1:0] a,
                           input logic [ELEM_W-1:0] b, input bit known, input result_t want);
    int unsigned pause;
    result_t     got;
    pause = draw_gap(tx_quiet);
    if (pause != 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.elem_a    <= a;
    in_ch.elem_b    <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    got = dsu_apply(op, a, b);
    pending_results.push_back(known ? want : got);
    op_seen[op]++;
    @(negedge clk);
  endtask

  // Change the link scheme only with the engine idle: drain every result first.
  task automatic set_scheme(input logic [1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    scheme = v;
    schemes_used[v] = 1'b1;
  endtask

  // Pick an operand: mostly a live element, sometimes any index so missing ones show up.
  function automatic logic [ELEM_W-1:0] pick_elem();
    if (made_list.size() != 0 && $urandom_range(0, 9) != 0)
      return made_list[$urandom_range(0, made_list.size() - 1)];
    return ELEM_W'($urandom_range(0, ELEM_CNT - 1));
  endfunction

  // Main stimulus: reset, directed plan, then random phases across the schemes.
  initial begin
    plan_row_t         row;
    int                ph;
    int                tries;
    int unsigned       r;
    op_t               op;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= SCHEME_BOTH;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_MAKE;
    in_ch.elem_a    <= '0;
    in_ch.elem_b    <= '0;
    for (int i = 0; i < ELEM_CNT; i++) begin
      parent_of[i] = '0;
      rank_of[i]   = '0;
      made[i]      = 1'b0;
    end
    find_levels  = '0;
    scheme       = VARIANT_RESET;
    schemes_used = '0;
    schemes_used[VARIANT_RESET] = 1'b1;
    errors       = 0;
    deepest_find = 0;
    tx_quiet     = 0;

    // Directed plan. Hand-typed results only where the answer is obvious: the empty
    // table, the extreme indices and the error cases.
    plan_item(OP_FIND,  5,  0,  1, 1'b1, 0,  0);  // find on the empty table: missing
    plan_item(OP_COUNT, 63, 63, 1, 1'b0, 0,  0);  // count read right after reset
    plan_item(OP_UNION, 0,  63, 1, 1'b1, 0,  0);  // union with both operands missing
    plan_item(OP_MAKE,  0,  63, 1, 1'b0, 0,  0);
    plan_item(OP_MAKE,  63, 0,  1, 1'b0, 63, 0);
    plan_item(OP_MAKE,  63, 0,  1, 1'b1, 0,  0);  // duplicate make
    plan_item(OP_UNION, 0,  63, 1, 1'b0, 0,  2);  // equal rank: first operand's root wins
    plan_item(OP_UNION, 63, 0,  1, 1'b0, 0,  5);  // same set: common root, both finds counted
    plan_item(OP_FIND,  63, 0,  1, 1'b0, 0,  7);
    plan_item(OP_UNION, 0,  42, 1, 1'b1, 0,  7);  // second operand missing
    plan_item(OP_MAKE,  1,  0,  0, 1'b0, 0,  0);
    plan_item(OP_MAKE,  2,  0,  0, 1'b0, 0,  0);
    plan_item(OP_MAKE,  3,  0,  0, 1'b0, 0,  0);
    plan_item(OP_UNION, 1,  2,  0, 1'b0, 0,  0);
    plan_item(OP_UNION, 3,  0,  0, 1'b0, 0,  0);  // lower rank first: second root wins
    plan_scheme(SCHEME_NAIVE);
    plan_item(OP_MAKE,  4,  0,  0, 1'b0, 0,  0);
    plan_item(OP_UNION, 4,  0,  0, 1'b0, 0,  0);  // naive: first root wins despite rank
    plan_item(OP_FIND,  63, 0,  0, 1'b0, 0,  0);  // three-level climb, no relinking
    plan_scheme(SCHEME_SQUASH);
    plan_item(OP_FIND,  63, 0,  0, 1'b0, 0,  0);  // relinks the path to the root
    plan_item(OP_FIND,  63, 0,  0, 1'b0, 0,  0);  // now a short climb
    plan_scheme(SCHEME_RANK);
    plan_item(OP_UNION, 2,  3,  0, 1'b0, 0,  0);  // links stored under other schemes
    plan_item(OP_COUNT, 0,  0,  0, 1'b0, 0,  0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_SCHEME) set_scheme(row.scheme);
      else send_beat(row.op, row.a, row.b, row.known, row.want);
    end

    // Random phases: 0,1,2,3 then 0,3,2,1 so the schemes are visited in both cyclic orders.
    for (ph = 0; ph < PHASES; ph++) begin
      set_scheme((ph < 4) ? ph[1:0] : 2'((ph * 3) % 4));
      repeat (PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        a = pick_elem();
        b = ELEM_W'($urandom_range(0, ELEM_CNT - 1));
        if (r < 12) begin
          // make: aim at a fresh element, keep a duplicate if 8 redraws all hit created ones
          op = OP_MAKE;
          a = ELEM_W'($urandom_range(0, ELEM_CNT - 1));
          tries = 0;
          while (made[a] && tries < 8) begin
            a = ELEM_W'($urandom_range(0, ELEM_CNT - 1));
            tries++;
          end
        end else if (r < 50) begin
          op = OP_UNION;
          b = pick_elem();
        end else if (r < 88) begin
          op = OP_FIND;
        end else if (r < 96) begin
          op = OP_COUNT;
        end else begin
          op = op_t'($urandom_range(0, 3));
          a = ELEM_W'($urandom_range(0, ELEM_CNT - 1));
        end
        send_beat(op, a, b, 1'b0, '0);
      end
    end

    // Drain, then give a stray extra beat time to show up.
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d makes, %0d unions, %0d finds, %0d count reads; schemes %b",
             op_seen[OP_MAKE], op_seen[OP_UNION], op_seen[OP_FIND], op_seen[OP_COUNT],
             schemes_used);
    $display("%0d of %0d elements created, deepest climb %0d levels, find count %0d",
             made_list.size(), ELEM_CNT, deepest_find, find_levels);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stalls per beat, plus one long hold-off while the sender keeps
  // offering, so the engine fills up and drops in_ch.ready.
  initial begin
    int unsigned hold;
    bit          held;
    out_ch.ready <= 1'b0;
    rx_quiet = 0;
    held     = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = draw_gap(rx_quiet);
      if (!held && beats_rx >= HOLD_AFTER) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    result_t oldest;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      beats_rx++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("unexpected result beat: status %0d root %0d find_calls %0d",
                   out_ch.status, out_ch.root, out_ch.find_calls);
      end else begin
        oldest = pending_results.pop_front();
        if (out_ch.status !== oldest.status || out_ch.root !== oldest.root ||
            out_ch.find_calls !== oldest.find_calls) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("result %0d: want status %0d root %0d calls %0d, got %0d %0d %0d",
                     beats_rx, oldest.status, oldest.root, oldest.find_calls,
                     out_ch.status, out_ch.root, out_ch.find_calls);
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
